>>> sv/baro_pkg.sv
// Shared types and constants for the barometer compensation pipeline.
package baro_pkg;

  localparam int CfgWidth    = 16;
  localparam int CfgIdxWidth = 3;

  // Calibration register indexes on the write port.
  typedef enum logic [CfgIdxWidth-1:0] {
    REG_C1 = 3'd0,
    REG_C2 = 3'd1,
    REG_C3 = 3'd2,
    REG_C4 = 3'd3,
    REG_C5 = 3'd4,
    REG_C6 = 3'd5
  } cfg_reg_e;

  // Rated output range.
  localparam int TEMP_MIN = -4000;
  localparam int TEMP_MAX = 8500;
  localparam int PRES_MIN = 1000;
  localparam int PRES_MAX = 120000;

  // Temperature reference and low-temperature threshold offset (0.01 C).
  localparam int TEMP_REF     = 2000;
  localparam int LOW_TEMP_OFS = 3500;

  localparam int Latency = 9;

  typedef struct packed {
    logic [23:0] raw_pressure;
    logic [23:0] raw_temperature;
  } baro_in_t;

  typedef struct packed {
    logic signed [14:0] temperature;
    logic        [16:0] pressure;
    logic               clamped;
  } baro_out_t;

endpackage

>>> sv/barometer_pressure_temp_compensation.sv
// Top level of the barometer pressure and temperature compensation pipeline.
//
// Usage: write the six 16-bit calibration words C1..C6 through cfg_we_i,
// cfg_idx_i and cfg_wdata_i (index 0..5, others ignored) while no item is in
// flight. Present a raw pressure and temperature item on in_i with start_i;
// busy_o stays low, so an item is taken at every edge where start_i is high.
// Nine register stages follow: the difference to the reference temperature,
// the three calibration products and dT squared, the first-order terms, the
// squared low-temperature terms, the second-order corrections, the corrected
// offset and sensitivity, the split pressure product, its recombination and
// the final scale and clamp. The result shows on res_o from the last of these
// registers, with done_o high for one cycle. One item per cycle is
// sustained; the multipliers of each stage are combinational.
// The receiver cannot stall, so the pipeline always advances.
// Reset clears all calibration words to zero and drops every item in flight.
module barometer_pressure_temp_compensation (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [baro_pkg::CfgIdxWidth-1:0]      cfg_idx_i,
  input  logic [baro_pkg::CfgWidth-1:0]         cfg_wdata_i,
  input  logic                                  start_i,
  input  baro_pkg::baro_in_t                    in_i,
  output logic                                  busy_o,
  output logic                                  done_o,
  output baro_pkg::baro_out_t                   res_o
);

  logic [15:0] c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;
  logic [baro_pkg::Latency-1:0] vld_q;
  logic acc;

  // calibration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0; c2_q <= '0; c3_q <= '0;
      c4_q <= '0; c5_q <= '0; c6_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        baro_pkg::REG_C1: c1_q <= cfg_wdata_i;
        baro_pkg::REG_C2: c2_q <= cfg_wdata_i;
        baro_pkg::REG_C3: c3_q <= cfg_wdata_i;
        baro_pkg::REG_C4: c4_q <= cfg_wdata_i;
        baro_pkg::REG_C5: c5_q <= cfg_wdata_i;
        baro_pkg::REG_C6: c6_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;
  assign acc    = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[baro_pkg::Latency-2:0], acc};
    end
  end

  // ---- stage 1: dT
  logic signed [24:0] dt_d, dt_q;
  logic [23:0] d1_s1_q;
  assign dt_d = $signed({1'b0, in_i.raw_temperature}) - $signed({1'b0, c5_q, 8'h00});

  always_ff @(posedge clk_i) begin
    dt_q    <= dt_d;
    d1_s1_q <= in_i.raw_pressure;
  end

  // ---- stage 2: products with calibration words and dT squared
  logic signed [41:0] p6_d, p4_d, p3_d, p6_q, p4_q, p3_q;
  logic signed [49:0] dsq;
  logic [47:0] pdd_q;
  logic [23:0] d1_s2_q;
  assign p6_d = dt_q * $signed({1'b0, c6_q});
  assign p4_d = dt_q * $signed({1'b0, c4_q});
  assign p3_d = dt_q * $signed({1'b0, c3_q});
  assign dsq  = dt_q * dt_q;

  always_ff @(posedge clk_i) begin
    p6_q    <= p6_d;
    p4_q    <= p4_d;
    p3_q    <= p3_d;
    pdd_q   <= dsq[47:0];
    d1_s2_q <= d1_s1_q;
  end

  // ---- stage 3: first-order terms
  logic signed [17:0] a_d, a_s3_q;
  logic signed [18:0] b_d, b_q;
  logic signed [36:0] off_d, off_s3_q;
  logic signed [35:0] sens_d, sens_s3_q;
  logic [16:0] t2_s3_q;
  logic [23:0] d1_s3_q;
  // a is TEMP minus the reference, b is TEMP above the low threshold
  assign a_d    = p6_q[40:23];
  assign b_d    = $signed({a_d[17], a_d}) + 19'(baro_pkg::LOW_TEMP_OFS);
  assign off_d  = $signed({4'b0, c2_q, 17'b0}) + $signed({p4_q[41], p4_q[41:6]});
  assign sens_d = $signed({4'b0, c1_q, 16'b0}) + $signed({p3_q[41], p3_q[41:7]});

  always_ff @(posedge clk_i) begin
    a_s3_q    <= a_d;
    b_q       <= b_d;
    off_s3_q  <= off_d;
    sens_s3_q <= sens_d;
    t2_s3_q   <= pdd_q[47:31];
    d1_s3_q   <= d1_s2_q;
  end

  // ---- stage 4: squares for the second-order terms
  logic signed [35:0] asq;
  logic signed [37:0] bsq;
  logic [34:0] aa_q, bb_q;
  logic lt_ref_q, lt_low_q;
  logic signed [17:0] a_s4_q;
  logic signed [36:0] off_s4_q;
  logic signed [35:0] sens_s4_q;
  logic [16:0] t2_s4_q;
  logic [23:0] d1_s4_q;
  assign asq = a_s3_q * a_s3_q;
  assign bsq = b_q * b_q;

  always_ff @(posedge clk_i) begin
    aa_q      <= asq[34:0];
    bb_q      <= bsq[34:0];
    lt_ref_q  <= a_s3_q[17];
    lt_low_q  <= b_q[18];
    a_s4_q    <= a_s3_q;
    off_s4_q  <= off_s3_q;
    sens_s4_q <= sens_s3_q;
    t2_s4_q   <= t2_s3_q;
    d1_s4_q   <= d1_s3_q;
  end

  // ---- stage 5: second-order corrections and corrected temperature
  logic [40:0] aa61;
  logic [38:0] bb15;
  logic [39:0] off2_d, off2_q;
  logic [38:0] sens2_d, sens2_q;
  logic signed [19:0] temp_d, temp_s5_q;
  logic signed [36:0] off_s5_q;
  logic signed [35:0] sens_s5_q;
  logic [23:0] d1_s5_q;
  assign aa61 = {6'd0, aa_q} * 41'd61;
  assign bb15 = {4'd0, bb_q} * 39'd15;

  always_comb begin
    off2_d  = '0;
    sens2_d = '0;
    temp_d  = $signed({{2{a_s4_q[17]}}, a_s4_q}) + 20'(baro_pkg::TEMP_REF);
    if (lt_ref_q) begin
      off2_d  = {3'b0, aa61[40:4]};
      sens2_d = {3'b0, aa_q, 1'b0};
      temp_d  = temp_d - $signed({3'b0, t2_s4_q});
      if (lt_low_q) begin
        off2_d  = off2_d + {1'b0, bb15};
        sens2_d = sens2_d + {1'b0, bb_q, 3'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    off2_q    <= off2_d;
    sens2_q   <= sens2_d;
    temp_s5_q <= temp_d;
    off_s5_q  <= off_s4_q;
    sens_s5_q <= sens_s4_q;
    d1_s5_q   <= d1_s4_q;
  end

  // ---- stage 6: corrected offset and sensitivity, temperature clamp
  logic signed [41:0] offc_d, sensc_d, offc_s6_q, sensc_q;
  logic signed [14:0] tsat_d, tsat_s6_q;
  logic tclamp_d, tclamp_s6_q;
  logic [23:0] d1_s6_q;
  assign offc_d  = $signed({{5{off_s5_q[36]}}, off_s5_q}) - $signed({2'b0, off2_q});
  assign sensc_d = $signed({{6{sens_s5_q[35]}}, sens_s5_q}) - $signed({3'b0, sens2_q});

  always_comb begin
    tsat_d   = temp_s5_q[14:0];
    tclamp_d = 1'b0;
    if (temp_s5_q < baro_pkg::TEMP_MIN) begin
      tsat_d   = 15'(baro_pkg::TEMP_MIN);
      tclamp_d = 1'b1;
    end else if (temp_s5_q > baro_pkg::TEMP_MAX) begin
      tsat_d   = 15'(baro_pkg::TEMP_MAX);
      tclamp_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    offc_s6_q   <= offc_d;
    sensc_q     <= sensc_d;
    tsat_s6_q   <= tsat_d;
    tclamp_s6_q <= tclamp_d;
    d1_s6_q     <= d1_s5_q;
  end

  // ---- stage 7: pressure product split into two partial products
  logic [44:0] plo_d, plo_q;
  logic signed [45:0] phi_d, phi_q;
  logic signed [41:0] offc_s7_q;
  logic signed [14:0] tsat_s7_q;
  logic tclamp_s7_q;
  assign plo_d = {21'd0, d1_s6_q} * {24'd0, sensc_q[20:0]};
  assign phi_d = $signed({1'b0, d1_s6_q}) * $signed(sensc_q[41:21]);

  always_ff @(posedge clk_i) begin
    plo_q       <= plo_d;
    phi_q       <= phi_d;
    offc_s7_q   <= offc_s6_q;
    tsat_s7_q   <= tsat_s6_q;
    tclamp_s7_q <= tclamp_s6_q;
  end

  // ---- stage 8: recombine; the high part already carries the 2^21 scale
  logic signed [45:0] x_d, x_q;
  logic signed [41:0] offc_s8_q;
  logic signed [14:0] tsat_s8_q;
  logic tclamp_s8_q;
  assign x_d = phi_q + $signed({22'd0, plo_q[44:21]});

  always_ff @(posedge clk_i) begin
    x_q         <= x_d;
    offc_s8_q   <= offc_s7_q;
    tsat_s8_q   <= tsat_s7_q;
    tclamp_s8_q <= tclamp_s7_q;
  end

  // ---- stage 9: subtract offset, scale, clamp pressure
  logic signed [46:0] y;
  logic signed [31:0] pres;
  baro_pkg::baro_out_t res_d, res_q;
  assign y    = $signed({x_q[45], x_q}) - $signed({{5{offc_s8_q[41]}}, offc_s8_q});
  assign pres = y[46:15];

  always_comb begin
    res_d.temperature = tsat_s8_q;
    res_d.pressure    = pres[16:0];
    res_d.clamped     = tclamp_s8_q;
    if (pres < baro_pkg::PRES_MIN) begin
      res_d.pressure = 17'(baro_pkg::PRES_MIN);
      res_d.clamped  = 1'b1;
    end else if (pres > baro_pkg::PRES_MAX) begin
      res_d.pressure = 17'(baro_pkg::PRES_MAX);
      res_d.clamped  = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o  = res_q;
  assign done_o = vld_q[baro_pkg::Latency-1];

  // ---- checks
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> ##9 done_o)
    else $error("item did not complete after the pipeline latency");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(acc, 9))
    else $error("result without a matching item");

  a_temp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($signed(res_o.temperature) >= baro_pkg::TEMP_MIN &&
                $signed(res_o.temperature) <= baro_pkg::TEMP_MAX))
    else $error("temperature outside rated range");

  a_pres_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.pressure >= baro_pkg::PRES_MIN &&
                res_o.pressure <= baro_pkg::PRES_MAX))
    else $error("pressure outside rated range");

endmodule

>>> verif/baro_comp_checker.sv
`timescale 1ns / 1ps
// Checker for the compensation block: predicts each item's result and compares it.
module baro_comp_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [baro_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [baro_pkg::CfgWidth-1:0]    cfg_wdata_i,
  input  logic                             start_i,
  input  logic                             busy_i,
  input  baro_pkg::baro_in_t               in_i,
  input  logic                             done_i,
  input  baro_pkg::baro_out_t              res_i,
  output int                               fail_count_o,
  output int                               taken_count_o,
  output int                               checked_count_o,
  output int                               clamped_count_o,
  output int                               cold_count_o
);

  logic [baro_pkg::CfgWidth-1:0] cal_q [6];
  baro_pkg::baro_out_t           expected_q [$];

  // Datasheet integer compensation, 64-bit signed throughout.
  function automatic baro_pkg::baro_out_t compensate(input baro_pkg::baro_in_t item);
    longint    d1, d2, c1, c2, c3, c4, c5, c6;
    longint    dt, t_first, offset, sens, t2, off2, sens2, dev, cold, temp, pres;
    baro_pkg::baro_out_t r;
    d1 = longint'({40'd0, item.raw_pressure});
    d2 = longint'({40'd0, item.raw_temperature});
    c1 = longint'({48'd0, cal_q[baro_pkg::REG_C1]});
    c2 = longint'({48'd0, cal_q[baro_pkg::REG_C2]});
    c3 = longint'({48'd0, cal_q[baro_pkg::REG_C3]});
    c4 = longint'({48'd0, cal_q[baro_pkg::REG_C4]});
    c5 = longint'({48'd0, cal_q[baro_pkg::REG_C5]});
    c6 = longint'({48'd0, cal_q[baro_pkg::REG_C6]});
    dt      = d2 - c5 * 256;
    t_first = baro_pkg::TEMP_REF + ((dt * c6) >>> 23);
    offset  = c2 * 131072 + ((dt * c4) >>> 6);
    sens    = c1 * 65536 + ((dt * c3) >>> 7);
    t2      = 0;
    off2    = 0;
    sens2   = 0;
    // Second-order terms are keyed off the first-order temperature.
    if (t_first < baro_pkg::TEMP_REF) begin
      dev   = t_first - baro_pkg::TEMP_REF;
      t2    = (dt * dt) >>> 31;
      off2  = (61 * dev * dev) >>> 4;
      sens2 = 2 * dev * dev;
      if (t_first < baro_pkg::TEMP_REF - baro_pkg::LOW_TEMP_OFS) begin
        cold  = t_first - baro_pkg::TEMP_REF + baro_pkg::LOW_TEMP_OFS;
        off2  = off2 + 15 * cold * cold;
        sens2 = sens2 + 8 * cold * cold;
      end
    end
    temp = t_first - t2;
    pres = (((d1 * (sens - sens2)) >>> 21) - (offset - off2)) >>> 15;
    r.clamped = 1'b0;
    if (temp < baro_pkg::TEMP_MIN) begin
      temp = baro_pkg::TEMP_MIN;
      r.clamped = 1'b1;
    end
    if (temp > baro_pkg::TEMP_MAX) begin
      temp = baro_pkg::TEMP_MAX;
      r.clamped = 1'b1;
    end
    if (pres < baro_pkg::PRES_MIN) begin
      pres = baro_pkg::PRES_MIN;
      r.clamped = 1'b1;
    end
    if (pres > baro_pkg::PRES_MAX) begin
      pres = baro_pkg::PRES_MAX;
      r.clamped = 1'b1;
    end
    r.temperature = temp[14:0];
    r.pressure    = pres[16:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    baro_pkg::baro_out_t want;
    int                  bad;
    if (!rst_ni) begin
      for (int k = baro_pkg::REG_C1; k <= baro_pkg::REG_C6; k++) cal_q[k] <= '0;
      expected_q.delete();
      fail_count_o    <= 0;
      taken_count_o   <= 0;
      checked_count_o <= 0;
      clamped_count_o <= 0;
      cold_count_o    <= 0;
    end else begin
      // Writes beyond the last register are dropped.
      if (cfg_we_i && cfg_idx_i <= baro_pkg::REG_C6) cal_q[cfg_idx_i] <= cfg_wdata_i;

      if (done_i) begin
        if (expected_q.size() == 0) begin
          $error("result with no item outstanding: temperature %0d pressure %0d",
                 res_i.temperature, res_i.pressure);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_q.pop_front();
          bad  = 0;
          if (res_i.temperature !== want.temperature) begin
            $error("temperature: expected %0d, actual %0d", want.temperature,
                   res_i.temperature);
            bad++;
          end
          if (res_i.pressure !== want.pressure) begin
            $error("pressure: expected %0d, actual %0d", want.pressure, res_i.pressure);
            bad++;
          end
          if (res_i.clamped !== want.clamped) begin
            $error("clamped: expected %0b, actual %0b", want.clamped, res_i.clamped);
            bad++;
          end
          fail_count_o    <= fail_count_o + bad;
          checked_count_o <= checked_count_o + 1;
        end
      end

      if (start_i && !busy_i) begin
        want = compensate(in_i);
        expected_q.push_back(want);
        taken_count_o <= taken_count_o + 1;
        if (want.clamped) clamped_count_o <= clamped_count_o + 1;
        if (want.temperature < baro_pkg::TEMP_REF) cold_count_o <= cold_count_o + 1;
      end
    end
  end

endmodule

>>> verif/barometer_pressure_temp_compensation_tb.sv
`timescale 1ns / 1ps
// Testbench top: drives readings and calibration sets into the block and gives the verdict.
module barometer_pressure_temp_compensation_tb;

  localparam int StallLimit = 400;
  localparam logic [baro_pkg::CfgIdxWidth-1:0] IdxSpare =
    baro_pkg::CfgIdxWidth'(baro_pkg::REG_C6 + 1);

  logic                             clk_i;
  logic                             rst_ni;
  logic                             cfg_we_i;
  logic [baro_pkg::CfgIdxWidth-1:0] cfg_idx_i;
  logic [baro_pkg::CfgWidth-1:0]    cfg_wdata_i;
  logic                             start_i;
  baro_pkg::baro_in_t               in_i;
  logic                             busy_o;
  logic                             done_o;
  baro_pkg::baro_out_t              res_o;

  int fails, taken, checked, clamped, cold;
  int idle_pct;
  int stall_cycles;

  logic [baro_pkg::CfgWidth-1:0] cal_now [6];
  logic [baro_pkg::CfgWidth-1:0] typical_cal [6] = '{16'd46372, 16'd43981, 16'd29059,
                                                     16'd27842, 16'd31553, 16'd28165};

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  barometer_pressure_temp_compensation u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start_i     (start_i),
    .in_i        (in_i),
    .busy_o      (busy_o),
    .done_o      (done_o),
    .res_o       (res_o)
  );

  baro_comp_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .start_i         (start_i),
    .busy_i          (busy_o),
    .in_i            (in_i),
    .done_i          (done_o),
    .res_i           (res_o),
    .fail_count_o    (fails),
    .taken_count_o   (taken),
    .checked_count_o (checked),
    .clamped_count_o (clamped),
    .cold_count_o    (cold)
  );

  // Write all six words, then poke the unused indexes, which must change nothing.
  task automatic load_calibration(input logic [baro_pkg::CfgWidth-1:0] words [6]);
    for (int k = baro_pkg::REG_C1; k <= baro_pkg::REG_C6; k++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= baro_pkg::CfgIdxWidth'(k);
      cfg_wdata_i <= words[k];
      cal_now[k]  = words[k];
      @(posedge clk_i);
    end
    cfg_idx_i   <= IdxSpare;
    cfg_wdata_i <= baro_pkg::CfgWidth'($urandom);
    @(posedge clk_i);
    cfg_idx_i   <= '1;
    cfg_wdata_i <= baro_pkg::CfgWidth'($urandom);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Drop start, wait for every outstanding result, then let the pipe run dry.
  task automatic settle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (taken != checked) @(posedge clk_i);
    repeat (baro_pkg::Latency + 2) @(posedge clk_i);
  endtask

  // Idle each cycle with the given chance, so idle_pct is the share of idle cycles.
  task automatic send_reading(input logic [23:0] d1, input logic [23:0] d2);
    logic ready;
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      in_i    <= {24'($urandom), 24'($urandom)};
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    in_i    <= {d1, d2};
    do begin
      @(negedge clk_i);
      ready = !busy_o;
      @(posedge clk_i);
    end while (!ready);
  endtask

  // Mostly plausible readings around the reference temperature, the rest raw noise.
  task automatic run_random(input int count);
    int base, spread, d2v;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 65) begin
        base   = int'(cal_now[baro_pkg::REG_C5]) * 256;
        spread = int'($urandom_range(4_000_000));
        d2v    = base + spread - 2_000_000;
        if (d2v < 0) d2v = 0;
        if (d2v > 16777215) d2v = 16777215;
        send_reading(24'($urandom_range(1_500_000, 12_000_000)), 24'(d2v));
      end else begin
        send_reading(24'($urandom), 24'($urandom));
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [baro_pkg::CfgWidth-1:0] plan [6];
    logic [baro_pkg::CfgWidth-1:0] ones [6];
    logic [23:0]                   ref_d2;
    start_i     <= 1'b0;
    in_i        <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= baro_pkg::REG_C1;
    cfg_wdata_i <= '0;
    rst_ni      <= 1'b0;
    idle_pct     = 0;
    for (int k = baro_pkg::REG_C1; k <= baro_pkg::REG_C6; k++) begin
      cal_now[k] = '0;
      ones[k]    = '1;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Calibration still at its reset value.
    send_reading(24'h000000, 24'h000000);
    send_reading(24'hFFFFFF, 24'hFFFFFF);
    send_reading(24'hFFFFFF, 24'h000000);
    settle();

    load_calibration(typical_cal);
    ref_d2 = 24'(int'(cal_now[baro_pkg::REG_C5]) * 256);
    send_reading(24'd6465444, 24'd8077636);
    send_reading(24'd6465444, ref_d2);             // exactly at the first threshold
    send_reading(24'd6465444, ref_d2 - 24'd1);     // just below it
    send_reading(24'd6465444, ref_d2 - 24'd1042000); // just above the cold threshold
    send_reading(24'd6465444, ref_d2 - 24'd1043000); // just below it
    send_reading(24'd6465444, 24'h000000);         // far too cold
    send_reading(24'd6465444, 24'hFFFFFF);         // far too hot
    send_reading(24'h000000, ref_d2);              // pressure under range
    send_reading(24'hFFFFFF, ref_d2);              // pressure over range
    send_reading(24'hFFFFFF, 24'h000000);
    send_reading(24'h000000, 24'hFFFFFF);
    send_reading(24'hAAAAAA, 24'h555555);
    send_reading(24'h555555, 24'hAAAAAA);
    settle();

    load_calibration(ones);
    send_reading(24'h000000, 24'h000000);
    send_reading(24'hFFFFFF, 24'hFFFFFF);
    send_reading(24'h800000, 24'hFF0000);
    send_reading(24'd6465444, 24'd8077636);
    settle();

    // Sender idles 30 percent, with one full drain in the middle.
    load_calibration(typical_cal);
    idle_pct = 30;
    run_random(250);
    settle();
    run_random(250);
    settle();

    // Sender idles 65 percent over two perturbed calibration sets.
    idle_pct = 65;
    repeat (2) begin
      for (int k = baro_pkg::REG_C1; k <= baro_pkg::REG_C6; k++)
        plan[k] = baro_pkg::CfgWidth'(typical_cal[k] + $urandom_range(8000) - 4000);
      load_calibration(plan);
      run_random(225);
      settle();
    end

    // Back to back: arbitrary calibration, the top extreme, then a perturbed set.
    idle_pct = 0;
    for (int k = baro_pkg::REG_C1; k <= baro_pkg::REG_C6; k++)
      plan[k] = baro_pkg::CfgWidth'($urandom);
    load_calibration(plan);
    run_random(200);
    settle();
    load_calibration(ones);
    run_random(100);
    settle();
    for (int k = baro_pkg::REG_C1; k <= baro_pkg::REG_C6; k++)
      plan[k] = baro_pkg::CfgWidth'(typical_cal[k] + $urandom_range(8000) - 4000);
    load_calibration(plan);
    run_random(200);
    settle();

    $display("Checked %0d of %0d readings: zero, typical, perturbed, random, full-scale cal.",
             checked, taken);
    $display("%0d readings needed the low-temperature correction, %0d hit the rated limits.",
             cold, clamped);
    if (fails == 0 && checked == taken) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
